FILE: rtl/ptsel_pkg.sv
// ----------------------------------------------------------------------------
// Percentile threshold select package
// Shared types and constants for the percentile threshold select block.
// ----------------------------------------------------------------------------
package ptsel_pkg;

    // Input magnitude width, threshold width and result count width.
    localparam int MAG_IN_W     = 16;
    localparam int THR_W        = 16;
    localparam int VCNT_W       = 11;

    // Percentile register: Q1.16 fraction, the integer bit so that one is representable.
    localparam int FRAC_W       = 17;
    localparam int FRAC_FBITS   = 16;
    localparam logic [FRAC_W-1:0] FRAC_RESET = 17'd58982;

    typedef struct packed {
        logic [MAG_IN_W-1:0] magnitude;
        logic                valid_req;
        logic                last;
    } t_item;

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [VCNT_W-1:0] valid_count;
        logic              empty_res;
        logic              overflow;
    } t_result;

endpackage

FILE: rtl/ptsel_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptsel_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ptsel_select.sv
// ----------------------------------------------------------------------------
// Percentile threshold select engine
// Computes the rank k from the percentile and finds the k-th smallest stored
// magnitude one bit at a time, scanning the store once per bit.
// ----------------------------------------------------------------------------
module ptsel_select #(
    parameter int MAX_POINTS = 1024,
    parameter int MAG_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_go,
    input  logic [$clog2(MAX_POINTS+1)-1:0]   i_count,
    input  logic [ptsel_pkg::FRAC_W-1:0]      i_frac,
    output logic                              o_rd_en,
    output logic [$clog2(MAX_POINTS)-1:0]     o_rd_addr,
    input  logic [MAG_BITS-1:0]               i_rd_data,
    output logic                              o_done,
    output logic [MAG_BITS-1:0]               o_value
);

    import ptsel_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int PW = FRAC_W + CW;
    localparam int KW = PW - FRAC_FBITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_KSET,
        S_SCAN,
        S_DECIDE
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_n;
    logic [FRAC_W-1:0]   r_frac;
    logic [PW-1:0]       r_prod;
    logic [CW-1:0]       r_k;
    logic [CW-1:0]       r_cnt;
    logic [AW-1:0]       r_addr;
    logic                r_issue;
    logic                r_rd_vld;
    logic                r_rd_last;
    logic [MAG_BITS-1:0] r_prefix;
    logic [MAG_BITS-1:0] r_himask;
    logic [MAG_BITS-1:0] r_bitsel;
    logic                r_done;
    logic [MAG_BITS-1:0] r_value;

    logic [CW-1:0]       w_nm1;
    logic [KW-1:0]       w_kraw;
    logic [CW-1:0]       w_kclamp;
    logic                w_addr_last;
    logic                w_match;
    logic                w_take_one;
    logic [MAG_BITS-1:0] n_prefix;

    always_comb begin
        w_nm1       = r_n - CW'(1);
        w_kraw      = r_prod[PW-1:FRAC_FBITS];
        w_kclamp    = (w_kraw > KW'(w_nm1)) ? w_nm1 : w_kraw[CW-1:0];
        w_addr_last = (CW'(r_addr) == w_nm1);
        // An entry counts when its bits above the current one match the
        // prefix found so far and the current bit is zero.
        w_match     = ((i_rd_data & r_himask) == r_prefix);
        w_take_one  = (r_k >= r_cnt);
        n_prefix    = w_take_one ? (r_prefix | r_bitsel) : r_prefix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issue   <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done    <= 1'b0;
            r_rd_vld  <= r_issue;
            r_rd_last <= r_issue && w_addr_last;
            unique case (r_state)
                S_IDLE: begin
                    if (i_go) begin
                        r_n     <= i_count;
                        r_frac  <= i_frac;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PW'(r_frac) * PW'(r_n);
                    r_state <= S_KSET;
                end
                S_KSET: begin
                    r_k      <= w_kclamp;
                    r_cnt    <= '0;
                    r_addr   <= '0;
                    r_issue  <= 1'b1;
                    r_prefix <= '0;
                    r_himask <= {1'b1, {(MAG_BITS-1){1'b0}}};
                    r_bitsel <= {1'b1, {(MAG_BITS-1){1'b0}}};
                    r_state  <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_issue) begin
                        if (w_addr_last) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + AW'(1);
                        end
                    end
                    if (r_rd_vld && w_match) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    if (r_rd_last) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_prefix <= n_prefix;
                    if (w_take_one) begin
                        r_k <= r_k - r_cnt;
                    end
                    if (r_bitsel[0]) begin
                        r_done  <= 1'b1;
                        r_value <= n_prefix;
                        r_state <= S_IDLE;
                    end else begin
                        r_bitsel <= {1'b0, r_bitsel[MAG_BITS-1:1]};
                        r_himask <= {1'b1, r_himask[MAG_BITS-1:1]};
                        r_cnt    <= '0;
                        r_addr   <= '0;
                        r_issue  <= 1'b1;
                        r_state  <= S_SCAN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rd_en   = r_issue;
    assign o_rd_addr = r_addr;
    assign o_done    = r_done;
    assign o_value   = r_value;

endmodule

FILE: rtl/percentile_threshold_select_top.sv
// ----------------------------------------------------------------------------
// Percentile threshold select, top level
// Collects a set of magnitudes and returns the value at a given percentile.
// ----------------------------------------------------------------------------
// Usage:
// Magnitudes arrive on i_item, one transaction per clock while busy is low:
// an item is taken at each rising edge with start high and busy low. Items
// with valid_req low are skipped; valid items go into a store of MAX_POINTS
// entries, and further valid items are dropped and reported as overflow.
// Loading runs at one item per cycle. The item with last high closes the set.
// For a non-empty set busy rises after the last item, and the block ranks the
// store bit by bit: one shared counting unit reads one store entry per cycle,
// so the selection scans all n stored values once for each of the MAG_BITS
// bits, through that single read port and counter. For an empty set the
// result comes the cycle after the last item and busy stays low.
// The result transaction is shown on o_result for exactly one cycle with
// o_done high; the receiver cannot stall it. busy falls in that same cycle,
// so the next set may start at once.
// The percentile register is written through i_cfg_we / i_cfg_data while the
// block is idle. Reset (synchronous, active low) empties the set, clears the
// overflow flag and sets the percentile to about 0.9; the store is not cleared.
// ----------------------------------------------------------------------------
module percentile_threshold_select_top #(
    parameter int MAX_POINTS = 1024,
    parameter int MAG_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  ptsel_pkg::t_item              i_item,
    input  logic                          i_cfg_we,
    input  logic [ptsel_pkg::FRAC_W-1:0]  i_cfg_data,
    output logic                          o_done,
    output ptsel_pkg::t_result            o_result
);

    import ptsel_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = $clog2(MAX_POINTS);

    // Control state.
    logic                r_busy;
    logic [CW-1:0]       r_count;
    logic                r_ovf;
    logic [FRAC_W-1:0]   r_frac;
    logic                r_done;
    // Result payload, held for the whole selection.
    logic [CW-1:0]       r_n;
    logic                r_ovf_set;
    t_result             r_result;

    logic                w_accept;
    logic                w_full;
    logic                w_store;
    logic [CW-1:0]       n_count;
    logic                n_ovf;
    logic [31:0]         w_mag_ext;
    logic [31:0]         w_n_ext;
    logic [31:0]         w_thr_ext;

    logic                w_sel_go;
    logic                w_rd_en;
    logic [AW-1:0]       w_rd_addr;
    logic [MAG_BITS-1:0] w_rd_data;
    logic                w_sel_done;
    logic [MAG_BITS-1:0] w_sel_value;

    always_comb begin
        w_accept  = start && !r_busy;
        w_full    = (r_count == CW'(MAX_POINTS));
        w_store   = w_accept && i_item.valid_req && !w_full;
        n_count   = r_count + CW'(w_store);
        n_ovf     = r_ovf || (w_accept && i_item.valid_req && w_full);
        w_sel_go  = w_accept && i_item.last && (n_count != '0);
        // The magnitude is kept in its low MAG_BITS bits.
        w_mag_ext = {16'h0000, i_item.magnitude};
        w_n_ext   = 32'(r_n);
        w_thr_ext = 32'(w_sel_value);
    end

    ptsel_ram #(
        .WIDTH (MAG_BITS),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_mag_ext[MAG_BITS-1:0]),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    ptsel_select #(
        .MAX_POINTS (MAX_POINTS),
        .MAG_BITS   (MAG_BITS)
    ) u_select (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (w_sel_go),
        .i_count   (n_count),
        .i_frac    (r_frac),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_done    (w_sel_done),
        .o_value   (w_sel_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_frac  <= FRAC_RESET;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_frac <= i_cfg_data;
            end
            if (w_accept) begin
                if (i_item.last) begin
                    // Close the set and start over for the next one.
                    r_n       <= n_count;
                    r_ovf_set <= n_ovf;
                    r_count   <= '0;
                    r_ovf     <= 1'b0;
                    if (n_count == '0) begin
                        // Empty set: answer at once with a zero threshold.
                        r_done               <= 1'b1;
                        r_result.threshold   <= '0;
                        r_result.valid_count <= '0;
                        r_result.empty_res   <= 1'b1;
                        r_result.overflow    <= n_ovf;
                    end else begin
                        r_busy <= 1'b1;
                    end
                end else begin
                    r_count <= n_count;
                    r_ovf   <= n_ovf;
                end
            end
            if (w_sel_done) begin
                r_busy               <= 1'b0;
                r_done               <= 1'b1;
                r_result.threshold   <= w_thr_ext[THR_W-1:0];
                r_result.valid_count <= w_n_ext[VCNT_W-1:0];
                r_result.empty_res   <= 1'b0;
                r_result.overflow    <= r_ovf_set;
            end
        end
    end

    assign busy     = r_busy;
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: rtl/ptsel_checker.sv
// ----------------------------------------------------------------------------
// Percentile threshold select checker
// Port-level checks on the busy window and the result transaction.
// ----------------------------------------------------------------------------
module ptsel_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input ptsel_pkg::t_item   i_item,
    input logic               o_done,
    input ptsel_pkg::t_result o_result
);

    import ptsel_pkg::*;

    // The block only goes busy after it took an item that closed a set.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && i_item.last))
        else $error("busy rose without a closing item");

    // No result is shown while a selection is still running.
    a_no_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_done)
        else $error("result shown while busy");

    // The end of a selection always delivers a non-empty result.
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_done && !o_result.empty_res))
        else $error("selection ended without a result");

    // An empty set reports a zero threshold and a zero count.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.empty_res) |->
            (o_result.threshold == '0 && o_result.valid_count == '0))
        else $error("empty result with nonzero fields");

endmodule

bind percentile_threshold_select_top ptsel_checker u_ptsel_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_done   (o_done),
    .o_result (o_result)
);
